### src/chacha_pkg.sv
// chacha20 stream cipher types, constants and helper functions
`timescale 1ns / 1ps

package chacha_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 64;

  typedef logic [31:0] word_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKey0    = 4'd0,
    CfgKey1    = 4'd1,
    CfgKey2    = 4'd2,
    CfgKey3    = 4'd3,
    CfgNonceLo = 4'd4,
    CfgNonceHi = 4'd5,
    CfgInitCtr = 4'd6,
    CfgConstSel = 4'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StRound = 4'b0010,
    StFeed  = 4'b0100,
    StEmit  = 4'b1000
  } state_e;

  localparam word_t ConstStd [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };
  localparam word_t ConstAlt [4] = '{
    32'h636E6144, 32'h52664F65, 32'h626F6C61, 32'h6E6F7265
  };

  // left rotation for the four quarter-round steps
  function automatic word_t qr_rotl(input word_t v, input logic [1:0] step);
    word_t r;
    case (step)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

  // word index of one quarter-round role (a, b, c, d) for a lane
  function automatic logic [3:0] qr_idx(input logic diag, input logic [1:0] lane,
                                        input logic [1:0] role);
    logic [1:0] col;
    col = lane + (role * {1'b0, diag});
    return {role, col};
  endfunction

endpackage

### src/chacha20_stream_cipher_unit.sv
// chacha20 byte-stream cipher top level with shared four-lane quarter-round step unit
//
// usage: one byte enters on the input channel (data_byte_i, message_start_i) and
// one cipher byte leaves on the output channel; both use valid and stall, and a
// transfer happens at a clock edge with valid high and stall low.
// key, nonce, initial counter and constant select are written through the cfg
// channel (index, data); cfg_ready_o is always high, unknown indexes are dropped.
// message_start_i restarts the byte position and reloads the block counter.
// a byte inside a keystream block gives its result in the cycle after its
// transfer; a byte that opens a block first runs the round steps, where four
// quarter-round lanes do one add-xor-rotate step per cycle, then the
// feed-forward state and the output state, which waits while the output stalls.
// throughput: one byte per cycle inside a block while the output is not stalled.
// the block takes no byte while it builds a keystream block.
// reset: position and counter clear, so the first byte builds block zero unless it carries message_start_i;
// all configuration registers clear to zero.
// a stalled result holds in the output register; a new byte is taken only
// while the output register is empty or being drained.
`timescale 1ns / 1ps

module chacha20_stream_cipher_unit #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [chacha_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [chacha_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       data_byte_i,
  input  logic                             message_start_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       cipher_byte_o
);
  import chacha_pkg::*;

  localparam int unsigned NumSteps = DOUBLE_ROUNDS * 8;
  localparam int unsigned StepW    = $clog2(NumSteps);
  localparam logic [StepW-1:0] LastStep = StepW'(NumSteps - 1);

  logic [63:0] key_q [4];
  logic [63:0] nonce_lo_q;
  word_t       nonce_hi_q;
  word_t       init_ctr_q;
  logic        const_sel_q;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [5:0]       pos_q, pos_d;
  word_t            ctr_q, ctr_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic [7:0]       data_q, data_d;
  word_t            ww_q [16];
  word_t            ww_d [16];
  word_t            ww_step [16];
  word_t            init_w [16];

  logic  accept;
  logic  new_blk;
  logic  out_free;
  word_t ctr_start;
  word_t ctr_sel;
  logic [7:0] ks_byte;

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign cipher_byte_o = out_byte_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == StIdle) && out_free);
  assign accept     = in_valid_i && !in_stall_o;
  assign new_blk    = message_start_i || (pos_q == 6'd0);
  assign ctr_start  = message_start_i ? init_ctr_q : ctr_q;
  assign ctr_sel    = (state_q == StIdle) ? ctr_start : ctr_q;
  assign ks_byte    = ww_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        key_q[i] <= '0;
      end
      nonce_lo_q  <= '0;
      nonce_hi_q  <= '0;
      init_ctr_q  <= '0;
      const_sel_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgKey0:     key_q[0]    <= cfg_data_i;
        CfgKey1:     key_q[1]    <= cfg_data_i;
        CfgKey2:     key_q[2]    <= cfg_data_i;
        CfgKey3:     key_q[3]    <= cfg_data_i;
        CfgNonceLo:  nonce_lo_q  <= cfg_data_i;
        CfgNonceHi:  nonce_hi_q  <= cfg_data_i[31:0];
        CfgInitCtr:  init_ctr_q  <= cfg_data_i[31:0];
        CfgConstSel: const_sel_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_w[i] = const_sel_q ? ConstAlt[i] : ConstStd[i];
    end
    for (int i = 0; i < 4; i++) begin
      init_w[4 + 2 * i] = key_q[i][31:0];
      init_w[5 + 2 * i] = key_q[i][63:32];
    end
    init_w[12] = ctr_sel;
    init_w[13] = nonce_lo_q[31:0];
    init_w[14] = nonce_lo_q[63:32];
    init_w[15] = nonce_hi_q;
  end

  // four independent lanes, each doing x += y; z ^= x; z <<<= r
  always_comb begin
    logic [1:0] s;
    logic       diag;
    logic [3:0] xi, yi, zi;
    word_t      sum;
    s    = step_q[1:0];
    diag = step_q[2];
    for (int i = 0; i < 16; i++) begin
      ww_step[i] = ww_q[i];
    end
    for (int l = 0; l < 4; l++) begin
      xi  = qr_idx(diag, 2'(l), s[0] ? 2'd2 : 2'd0);
      yi  = qr_idx(diag, 2'(l), s[0] ? 2'd3 : 2'd1);
      zi  = qr_idx(diag, 2'(l), s[0] ? 2'd1 : 2'd3);
      sum = ww_q[xi] + ww_q[yi];
      ww_step[xi] = sum;
      ww_step[zi] = qr_rotl(ww_q[zi] ^ sum, s);
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    pos_d       = pos_q;
    ctr_d       = ctr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_byte_d  = out_byte_q;
    data_d      = data_q;
    for (int i = 0; i < 16; i++) begin
      ww_d[i] = ww_q[i];
    end
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          data_d = data_byte_i;
          if (new_blk) begin
            ctr_d   = ctr_start;
            step_d  = '0;
            state_d = StRound;
            for (int i = 0; i < 16; i++) begin
              ww_d[i] = init_w[i];
            end
          end else begin
            out_byte_d  = data_byte_i ^ ks_byte;
            out_valid_d = 1'b1;
            pos_d       = pos_q + 6'd1;
          end
        end
      end
      StRound: begin
        for (int i = 0; i < 16; i++) begin
          ww_d[i] = ww_step[i];
        end
        if (step_q == LastStep) begin
          state_d = StFeed;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      StFeed: begin
        for (int i = 0; i < 16; i++) begin
          ww_d[i] = ww_q[i] + init_w[i];
        end
        state_d = StEmit;
      end
      StEmit: begin
        if (out_free) begin
          out_byte_d  = data_q ^ ww_q[0][7:0];
          out_valid_d = 1'b1;
          pos_d       = 6'd1;
          ctr_d       = ctr_q + 32'd1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      pos_q       <= '0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      pos_q       <= pos_d;
      ctr_q       <= ctr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    data_q     <= data_d;
    for (int i = 0; i < 16; i++) begin
      ww_q[i] <= ww_d[i];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !new_blk) |=> (out_valid_o && (state_q == StIdle)))
    else $error("byte inside a block did not give a result in one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && new_blk) |=> ((state_q == StRound) && (step_q == '0)))
    else $error("block start did not enter the round sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFeed) |=> (state_q == StEmit))
    else $error("feed-forward not followed by output cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q == StIdle) || $past(state_q == StEmit)))
    else $error("result appeared outside idle or output cycle");

endmodule

### test/tb.sv
// self-checking testbench for the chacha20 byte-stream cipher unit
`timescale 1ns / 1ps

module tb;
  import chacha_pkg::*;

  localparam int unsigned NumRegs   = 8;
  localparam int unsigned HoldLen   = 250;
  localparam int unsigned IdleLimit = 4000;

  localparam word_t StdWords [4] = '{
    32'h61707865, 32'h3320646e, 32'h79622d32, 32'h6b206574
  };
  localparam word_t AltWords [4] = '{
    32'h636e6144, 32'h52664f65, 32'h626f6c61, 32'h6e6f7265
  };

  typedef enum logic [1:0] {
    SetupNone,
    SetupRfc,
    SetupAlt
  } setup_e;

  typedef struct {
    logic [7:0] data;
    logic       start;
    logic       typed;
    logic [7:0] want;
    setup_e     setup;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          data_byte_i;
  logic                message_start_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [7:0]          cipher_byte_o;

  // register shadow
  logic [63:0] key_r [4];
  logic [63:0] nonce_lo_r;
  logic [31:0] nonce_hi_r;
  logic [31:0] ctr_init_r;
  logic        alt_const_r;

  // keystream predictor state
  logic [7:0]  ks_block [64];
  logic [5:0]  ks_pos;
  logic [31:0] blk_ctr;
  word_t       mix_w [16];

  logic [7:0]  cipher_q [$];
  int          errors;
  bit          steady;
  bit          hold_rx;
  int unsigned idle_cycles;

  row_t rows [20] = '{
    '{8'h00, 1'b0, 1'b1, 8'h76, SetupNone},
    '{8'hff, 1'b0, 1'b1, 8'h47, SetupNone},
    '{8'ha5, 1'b0, 1'b0, 8'h00, SetupNone},
    '{8'h5a, 1'b0, 1'b0, 8'h00, SetupNone},
    '{8'h3c, 1'b0, 1'b0, 8'h00, SetupRfc},
    '{8'hc3, 1'b0, 1'b0, 8'h00, SetupNone},
    '{8'h00, 1'b1, 1'b0, 8'h00, SetupNone},
    '{8'hff, 1'b0, 1'b0, 8'h00, SetupNone},
    '{8'h80, 1'b0, 1'b0, 8'h00, SetupNone},
    '{8'h01, 1'b0, 1'b0, 8'h00, SetupNone},
    '{8'h7e, 1'b0, 1'b0, 8'h00, SetupNone},
    '{8'h55, 1'b1, 1'b0, 8'h00, SetupNone},
    '{8'haa, 1'b0, 1'b0, 8'h00, SetupNone},
    '{8'h00, 1'b1, 1'b0, 8'h00, SetupNone},
    '{8'hff, 1'b1, 1'b0, 8'h00, SetupNone},
    '{8'h0f, 1'b0, 1'b0, 8'h00, SetupAlt},
    '{8'hf0, 1'b1, 1'b0, 8'h00, SetupNone},
    '{8'h12, 1'b0, 1'b0, 8'h00, SetupNone},
    '{8'h34, 1'b1, 1'b0, 8'h00, SetupNone},
    '{8'h56, 1'b0, 1'b0, 8'h00, SetupNone}
  };

  chacha20_stream_cipher_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .message_start_i (message_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cipher_byte_o   (cipher_byte_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic word_t rotl(input word_t v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void quarter(input int a, input int b, input int c, input int d);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 16);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 12);
    mix_w[a] = mix_w[a] + mix_w[b]; mix_w[d] = rotl(mix_w[d] ^ mix_w[a], 8);
    mix_w[c] = mix_w[c] + mix_w[d]; mix_w[b] = rotl(mix_w[b] ^ mix_w[c], 7);
  endfunction

  function automatic void build_block(input word_t ctr);
    word_t init_w [16];
    word_t sum;
    for (int i = 0; i < 4; i++) begin
      init_w[i] = alt_const_r ? AltWords[i] : StdWords[i];
      init_w[4 + 2 * i] = key_r[i][31:0];
      init_w[5 + 2 * i] = key_r[i][63:32];
    end
    init_w[12] = ctr;
    init_w[13] = nonce_lo_r[31:0];
    init_w[14] = nonce_lo_r[63:32];
    init_w[15] = nonce_hi_r;
    for (int i = 0; i < 16; i++) mix_w[i] = init_w[i];
    for (int r = 0; r < 10; r++) begin
      quarter(0, 4, 8, 12);
      quarter(1, 5, 9, 13);
      quarter(2, 6, 10, 14);
      quarter(3, 7, 11, 15);
      quarter(0, 5, 10, 15);
      quarter(1, 6, 11, 12);
      quarter(2, 7, 8, 13);
      quarter(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) begin
      sum = mix_w[i] + init_w[i];
      for (int j = 0; j < 4; j++) ks_block[4 * i + j] = sum[8 * j +: 8];
    end
  endfunction

  function automatic logic [7:0] next_cipher(input logic [7:0] d, input logic s);
    logic [7:0] r;
    if (s) begin
      ks_pos  = '0;
      blk_ctr = ctr_init_r;
    end
    if (ks_pos == 6'd0) begin
      build_block(blk_ctr);
      blk_ctr = blk_ctr + 32'd1;
    end
    r = d ^ ks_block[ks_pos];
    ks_pos = ks_pos + 6'd1;
    return r;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgKey0:     key_r[0]    = val;
      CfgKey1:     key_r[1]    = val;
      CfgKey2:     key_r[2]    = val;
      CfgKey3:     key_r[3]    = val;
      CfgNonceLo:  nonce_lo_r  = val;
      CfgNonceHi:  nonce_hi_r  = val[31:0];
      CfgInitCtr:  ctr_init_r  = val[31:0];
      CfgConstSel: alt_const_r = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_all(input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3,
                           input logic [63:0] nlo, input logic [63:0] nhi,
                           input logic [63:0] ctr, input logic [63:0] sel);
    write_reg(CfgKey0, k0);
    write_reg(CfgKey1, k1);
    write_reg(CfgKey2, k2);
    write_reg(CfgKey3, k3);
    write_reg(CfgNonceLo, nlo);
    write_reg(CfgNonceHi, nhi);
    write_reg(CfgInitCtr, ctr);
    write_reg(CfgConstSel, sel);
    write_reg(CfgIdxW'(NumRegs + $urandom_range(0, 15 - NumRegs)), {$urandom, $urandom});
  endtask

  task automatic send_byte(input logic [7:0] d, input logic s, input logic typed,
                           input logic [7:0] want);
    int unsigned gap;
    logic [7:0]  pred;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    data_byte_i     = d;
    message_start_i = s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = next_cipher(d, s);
    cipher_q = {cipher_q, (typed ? want : pred)};
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (cipher_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // result side
  initial begin
    int unsigned wait_n;
    logic [7:0]  want;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      wait_n = steady ? 0 : $urandom_range(0, 3);
      if (hold_rx) begin
        hold_rx     = 1'b0;
        out_stall_i = 1'b1;
        repeat (HoldLen) @(negedge clk_i);
      end
      if (wait_n != 0) begin
        out_stall_i = 1'b1;
        repeat (wait_n) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (cipher_q.size() == 0) begin
        $error("cipher_byte: unexpected transfer, actual %h", cipher_byte_o);
        errors++;
      end else begin
        want = cipher_q.pop_front();
        if (cipher_byte_o !== want) begin
          $error("cipher_byte mismatch: expected %h, actual %h", want, cipher_byte_o);
          errors++;
        end
      end
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned budget;
    int unsigned len;
    logic        s;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    data_byte_i     = '0;
    message_start_i = 1'b0;
    errors          = 0;
    steady          = 1'b0;
    hold_rx         = 1'b0;
    idle_cycles     = 0;
    for (int i = 0; i < 4; i++) key_r[i] = '0;
    nonce_lo_r  = '0;
    nonce_hi_r  = '0;
    ctr_init_r  = '0;
    alt_const_r = 1'b0;
    ks_pos      = '0;
    blk_ctr     = '0;
    for (int i = 0; i < 64; i++) ks_block[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table
    foreach (rows[i]) begin
      if (rows[i].setup != SetupNone) begin
        drain();
        if (rows[i].setup == SetupRfc) begin
          write_all(64'h07060504_03020100, 64'h0f0e0d0c_0b0a0908,
                    64'h17161514_13121110, 64'h1f1e1d1c_1b1a1918,
                    64'h4a000000_09000000, 64'h0, 64'h1, 64'h0);
        end else begin
          write_reg(CfgConstSel, '1);
          write_reg(CfgInitCtr, 64'hffff_ffff_ffff_fffe);
          write_reg(CfgIdxW'(NumRegs + $urandom_range(0, 15 - NumRegs)),
                    {$urandom, $urandom});
        end
      end
      send_byte(rows[i].data, rows[i].start, rows[i].typed, rows[i].want);
    end

    // random phases of messages
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: write_all('0, '0, '0, '0, '0, '0, '0, 64'hffff_ffff_ffff_fffe);
        1: write_all('1, '1, '1, '1, '1, '1, '1, '1);
        default: write_all({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
      endcase
      steady  = (ph == 3);
      hold_rx = (ph == 2);
      sent    = 0;
      budget  = 20;
      while (sent < budget) begin
        if (ph == 1 && sent == 0) begin
          len = 140;
        end else if ($urandom_range(0, 3) == 0) begin
          len = $urandom_range(65, 130);
        end else begin
          len = $urandom_range(1, 40);
        end
        for (int k = 0; k < len; k++) begin
          s = (k == 0);
          if (sent == 0 && ph != 1) s = 1'($urandom_range(0, 1));
          else if ($urandom_range(0, 9) == 0) s = 1'($urandom_range(0, 1));
          send_byte(8'($urandom_range(0, 255)), s, 1'b0, 8'h00);
          sent++;
        end
      end
    end
    steady = 1'b0;

    drain();
    repeat (100) @(negedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
